// ----- hdl/sae_pkg.sv -----
package sae_pkg;
    localparam int MAX_LEN   = 4096;
    localparam int ALPHABET  = 26;
    localparam int NSTATES   = 2 * MAX_LEN;
    localparam int SW        = $clog2(NSTATES);
    localparam int LW        = $clog2(MAX_LEN + 1);
    localparam int CW        = $clog2(ALPHABET);
    localparam int TW        = SW + CW;
    localparam int DW        = 24;
    localparam logic [SW-1:0] ROOT = SW'(1);

    typedef logic [SW-1:0] st_t;
    typedef logic [LW-1:0] len_t;

    // One write request towards the state memories.
    typedef struct packed {
        logic         tr_we;
        logic [TW-1:0] tr_addr;
        st_t          tr_data;
        logic         sl_we;
        st_t          sl_addr;
        st_t          sl_data;
        logic         ln_we;
        st_t          ln_addr;
        len_t         ln_data;
    } mem_wr_t;

    // Read requests towards the state memories.
    typedef struct packed {
        logic [TW-1:0] tr_addr;
        st_t          sl_addr;
        st_t          ln_addr;
    } mem_rd_t;

    function automatic logic [TW-1:0] tr_index(st_t s, logic [CW-1:0] c);
        return TW'(s) * TW'(ALPHABET) + TW'(c);
    endfunction
endpackage

// ----- hdl/sae_mem.sv -----
module sae_mem
    import sae_pkg::*;
(
    input  logic    clk,
    input  mem_wr_t wr,
    input  mem_rd_t rd,
    output st_t     tr_q,
    output st_t     sl_q,
    output len_t    ln_q
);
    localparam int TDEPTH = NSTATES * ALPHABET;

    st_t  tr_mem [TDEPTH];
    st_t  sl_mem [NSTATES];
    len_t ln_mem [NSTATES];

    // Transition table.
    always_ff @(posedge clk)
    begin
        if (wr.tr_we)
        begin
            tr_mem[wr.tr_addr] <= wr.tr_data;
        end
        tr_q <= tr_mem[rd.tr_addr];
    end

    // Suffix links.
    always_ff @(posedge clk)
    begin
        if (wr.sl_we)
        begin
            sl_mem[wr.sl_addr] <= wr.sl_data;
        end
        sl_q <= sl_mem[rd.sl_addr];
    end

    // State lengths.
    always_ff @(posedge clk)
    begin
        if (wr.ln_we)
        begin
            ln_mem[wr.ln_addr] <= wr.ln_data;
        end
        ln_q <= ln_mem[rd.ln_addr];
    end
endmodule

// ----- hdl/suffix_automaton_extend_top.sv -----
// Online suffix automaton over 26 letters. Each request either clears the
// automaton (kind 0) or appends a letter (kind 1) and yields one result: the
// lengths of the substrings that appear for the first time and a running
// count of distinct substrings. All state lives in three single-port-read
// synchronous memories and one sequencer reads, modifies and writes them, so
// one request is handled at a time. A clear resets the automaton's
// registers; the first append after a clear re-creates the root. An append
// of a letter outside the alphabet, or when the table is full, is ignored.
// Otherwise the new state's row is cleared and a first suffix-link walk sets
// transitions until it runs past the root or stops at an existing one. In
// the latter case a state may be cloned, with its row copied, and a second
// walk redirects transitions to the clone and may stop early. The single
// transition write port clears and copies rows letter by letter. The
// sequencer returns to idle before the next request is taken. A finished
// result waits in the output register, so a stalled result only holds the
// sequencer once its next result is ready. Clearing needs no pass over the
// memories: entries are always written before they are read.
module suffix_automaton_extend_top
    import sae_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [4:0]       letter,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [12:0]      new_min_len,
    output logic [12:0]      new_max_len,
    output logic [DW-1:0]    distinct_total,
    output logic             table_full
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PLEN   = 5'd1;
    localparam logic [4:0] S_PLENW  = 5'd2;
    localparam logic [4:0] S_ROOT   = 5'd3;
    localparam logic [4:0] S_NEW    = 5'd4;
    localparam logic [4:0] S_CLRW   = 5'd5;
    localparam logic [4:0] S_W1RD   = 5'd6;
    localparam logic [4:0] S_W1WT   = 5'd7;
    localparam logic [4:0] S_W1CK   = 5'd8;
    localparam logic [4:0] S_QLEN   = 5'd9;
    localparam logic [4:0] S_QCHK   = 5'd10;
    localparam logic [4:0] S_CPWR   = 5'd11;
    localparam logic [4:0] S_CLINK  = 5'd12;
    localparam logic [4:0] S_W2RD   = 5'd13;
    localparam logic [4:0] S_W2WT   = 5'd14;
    localparam logic [4:0] S_W2CK   = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;
    localparam logic [4:0] S_FINW   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0]      state_reg, state_next;
    st_t             last_reg, last_next;
    st_t             cnt_reg, cnt_next;
    logic [DW-1:0]   dist_reg, dist_next;
    logic            empty_reg, empty_next;
    logic [CW-1:0]   c_reg, c_next;
    st_t             p_reg, p_next;
    st_t             np_reg, np_next;
    st_t             q_reg, q_next;
    st_t             nq_reg, nq_next;
    st_t             link_reg, link_next;
    len_t            plen_reg, plen_next;
    len_t            nplen_reg, nplen_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            ov_reg, ov_next;
    logic [12:0]     lo_reg, lo_next, hi_reg, hi_next;
    logic            full_reg, full_next;
    logic [12:0]     res_min_reg, res_min_next;
    logic [12:0]     res_max_reg, res_max_next;
    logic [DW-1:0]   res_total_reg, res_total_next;
    logic            res_full_reg, res_full_next;
    mem_wr_t         wr;
    mem_rd_t         rd;
    st_t             tr_q, sl_q;
    len_t            ln_q;
    st_t             cnt_inc;
    len_t            plen_inc;

    sae_mem u_mem (.clk(clk), .wr(wr), .rd(rd), .tr_q(tr_q), .sl_q(sl_q), .ln_q(ln_q));

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = ov_reg;
    assign new_min_len    = res_min_reg;
    assign new_max_len    = res_max_reg;
    assign distinct_total = res_total_reg;
    assign table_full     = res_full_reg;
    assign cnt_inc        = cnt_reg + ROOT;
    assign plen_inc       = plen_reg + len_t'(1);

    // Sequencer over the state memories.
    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        dist_next      = dist_reg;
        empty_next     = empty_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        np_next        = np_reg;
        q_next         = q_reg;
        nq_next        = nq_reg;
        link_next      = link_reg;
        plen_next      = plen_reg;
        nplen_next     = nplen_reg;
        k_next         = k_reg;
        ov_next        = ov_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        full_next      = full_reg;
        res_min_next   = res_min_reg;
        res_max_next   = res_max_reg;
        res_total_next = res_total_reg;
        res_full_next  = res_full_reg;
        wr             = '0;
        rd.tr_addr     = tr_index(p_reg, c_reg);
        rd.sl_addr     = p_reg;
        rd.ln_addr     = p_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lo_next   = '0;
                    hi_next   = '0;
                    full_next = 1'b0;
                    c_next    = letter[CW-1:0];
                    p_next    = last_reg;
                    k_next    = '0;
                    if (!kind)
                    begin
                        last_next  = ROOT;
                        cnt_next   = ROOT;
                        dist_next  = '0;
                        empty_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (empty_reg)
                    begin
                        // The root's length is zero and it must be created first.
                        plen_next  = '0;
                        state_next = (letter < 5'(ALPHABET)) ? S_ROOT : S_OUT;
                    end
                    else
                    begin
                        state_next = S_PLEN;
                    end
                end
            end
            S_PLEN:
            begin
                state_next = S_PLENW;
            end
            S_PLENW:
            begin
                plen_next = ln_q;
                k_next    = '0;
                if (ln_q >= LW'(MAX_LEN))
                begin
                    full_next  = 1'b1;
                    state_next = S_OUT;
                end
                else if (c_reg >= CW'(ALPHABET))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_ROOT:
            begin
                // A fresh root has no link, zero length and no transitions.
                wr.tr_we   = 1'b1;
                wr.tr_addr = tr_index(ROOT, k_reg);
                wr.tr_data = '0;
                wr.sl_we   = 1'b1;
                wr.sl_addr = ROOT;
                wr.sl_data = '0;
                wr.ln_we   = 1'b1;
                wr.ln_addr = ROOT;
                wr.ln_data = '0;
                k_next     = k_reg + CW'(1);
                if (k_reg == CW'(ALPHABET - 1))
                begin
                    empty_next = 1'b0;
                    k_next     = '0;
                    state_next = S_NEW;
                end
            end
            S_NEW:
            begin
                // Clear the new state's row, one letter a cycle.
                wr.tr_we   = 1'b1;
                wr.tr_addr = tr_index(cnt_inc, k_reg);
                wr.tr_data = '0;
                k_next     = k_reg + CW'(1);
                if (k_reg == CW'(ALPHABET - 1))
                begin
                    state_next = S_CLRW;
                end
            end
            S_CLRW:
            begin
                np_next    = cnt_inc;
                cnt_next   = cnt_inc;
                nplen_next = plen_inc;
                wr.ln_we   = 1'b1;
                wr.ln_addr = cnt_inc;
                wr.ln_data = plen_inc;
                last_next  = cnt_inc;
                state_next = S_W1RD;
            end
            S_W1RD:
            begin
                state_next = S_W1WT;
            end
            S_W1WT:
            begin
                if (tr_q == '0)
                begin
                    wr.tr_we   = 1'b1;
                    wr.tr_addr = tr_index(p_reg, c_reg);
                    wr.tr_data = np_reg;
                    p_next     = sl_q;
                    state_next = S_W1CK;
                end
                else
                begin
                    q_next     = tr_q;
                    plen_next  = ln_q;
                    state_next = S_QLEN;
                end
            end
            S_W1CK:
            begin
                if (p_reg == '0)
                begin
                    link_next  = ROOT;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_W1RD;
                end
            end
            S_QLEN:
            begin
                rd.ln_addr = q_reg;
                rd.sl_addr = q_reg;
                state_next = S_QCHK;
            end
            S_QCHK:
            begin
                if (ln_q == plen_inc)
                begin
                    link_next  = q_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    // The clone takes p's length plus one and q's old link.
                    nq_next    = cnt_inc;
                    cnt_next   = cnt_inc;
                    link_next  = cnt_inc;
                    wr.ln_we   = 1'b1;
                    wr.ln_addr = cnt_inc;
                    wr.ln_data = plen_inc;
                    wr.sl_we   = 1'b1;
                    wr.sl_addr = cnt_inc;
                    wr.sl_data = sl_q;
                    k_next     = '0;
                    rd.tr_addr = tr_index(q_reg, '0);
                    state_next = S_CPWR;
                end
            end
            S_CPWR:
            begin
                // Copy q's row into the clone, one letter a cycle.
                wr.tr_we   = 1'b1;
                wr.tr_addr = tr_index(nq_reg, k_reg);
                wr.tr_data = tr_q;
                k_next     = k_reg + CW'(1);
                rd.tr_addr = tr_index(q_reg, k_reg + CW'(1));
                state_next = (k_reg == CW'(ALPHABET - 1)) ? S_CLINK : S_CPWR;
            end
            S_CLINK:
            begin
                // q now links to the clone.
                wr.sl_we   = 1'b1;
                wr.sl_addr = q_reg;
                wr.sl_data = nq_reg;
                state_next = S_W2RD;
            end
            S_W2RD:
            begin
                state_next = S_W2WT;
            end
            S_W2WT:
            begin
                if (tr_q == q_reg)
                begin
                    wr.tr_we   = 1'b1;
                    wr.tr_addr = tr_index(p_reg, c_reg);
                    wr.tr_data = nq_reg;
                    p_next     = sl_q;
                    state_next = S_W2CK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_W2CK:
            begin
                state_next = (p_reg == '0) ? S_FIN : S_W2RD;
            end
            S_FIN:
            begin
                wr.sl_we   = 1'b1;
                wr.sl_addr = np_reg;
                wr.sl_data = link_reg;
                rd.ln_addr = link_reg;
                state_next = S_FINW;
            end
            S_FINW:
            begin
                lo_next    = 13'(ln_q) + 13'd1;
                hi_next    = 13'(nplen_reg);
                dist_next  = dist_reg + DW'(nplen_reg) - DW'(ln_q);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Load the output register once it is free.
                if (!ov_reg || !out_stall)
                begin
                    ov_next        = 1'b1;
                    res_min_next   = lo_reg;
                    res_max_next   = hi_reg;
                    res_total_next = dist_reg;
                    res_full_next  = full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= ROOT;
            cnt_reg       <= ROOT;
            dist_reg      <= '0;
            empty_reg     <= 1'b1;
            ov_reg        <= 1'b0;
            res_min_reg   <= '0;
            res_max_reg   <= '0;
            res_total_reg <= '0;
            res_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            dist_reg      <= dist_next;
            empty_reg     <= empty_next;
            ov_reg        <= ov_next;
            res_min_reg   <= res_min_next;
            res_max_reg   <= res_max_next;
            res_total_reg <= res_total_next;
            res_full_reg  <= res_full_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        p_reg     <= p_next;
        np_reg    <= np_next;
        q_reg     <= q_next;
        nq_reg    <= nq_next;
        link_reg  <= link_next;
        plen_reg  <= plen_next;
        nplen_reg <= nplen_next;
        k_reg     <= k_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        full_reg  <= full_next;
    end

    // The output register is only loaded when free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg)
        else $error("result dropped while stalled");
    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            $stable({new_min_len, new_max_len, distinct_total, table_full}))
        else $error("stalled result changed");
    // A request is taken only while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("request taken without leaving idle");
    // The state count never falls below the root.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0)
        else $error("state count lost the root");
endmodule
